/* design/rfae_pkg.sv */
// ---------------------------------------------------------------------------
// Rotor flux angle estimator package
// Fixed-point format, constants, state and operation codes.
// ---------------------------------------------------------------------------
package rfae_pkg;

   localparam int FRAC_BITS = 16;
   localparam int NUM_W     = 32 + FRAC_BITS;
   localparam int CNT_W     = $clog2(NUM_W + 1);

   localparam logic [63:0] TWO_PI_Q32 = 64'd26986075409;
   localparam logic [31:0] TWO_PI     = 32'(TWO_PI_Q32 >> (32 - FRAC_BITS));
   localparam logic [31:0] MIN_IMR    = 32'((64'd1 << FRAC_BITS) / 64'd1000);
   localparam logic [31:0] CLAMP_LIM  = 32'(((64'd1 << FRAC_BITS) - 64'd1) / 64'd1000);
   localparam logic [31:0] SAT_POS    = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG    = 32'h8000_0000;

   localparam logic [30:0] RESET_SAMPLE_PERIOD = 31'd655;
   localparam logic [30:0] RESET_ROTOR_TC      = 31'd65536;

   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_SAMPLE_PERIOD = 1'b0;
   localparam csr_index_type CSR_ROTOR_TC      = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RUN, ST_FIN, ST_POST, ST_CLAMP, ST_WLOAD
   } state_type;

   typedef enum logic [3:0] {
      OP_GAIN, OP_MIX, OP_DEN, OP_SLIP, OP_SAM, OP_SAW, OP_RAM, OP_RAW, OP_FAW
   } op_type;

   typedef enum logic [1:0] {KIND_MUL, KIND_DIV, KIND_MOD} kind_type;

   function automatic kind_type op_kind(input op_type op);
      kind_type k;
      case (op) inside
         OP_GAIN, OP_SLIP:        k = KIND_DIV;
         OP_SAW, OP_RAW, OP_FAW:  k = KIND_MOD;
         default:                 k = KIND_MUL;
      endcase
      return k;
   endfunction

endpackage

/* design/rotor_flux_angle_estimator_top.sv */
// ---------------------------------------------------------------------------
// Rotor flux angle estimator
// Magnetizing current, slip speed and flux angle, one update per request.
// ---------------------------------------------------------------------------
// Usage:
//  A request carries torque current, flux current and rotor speed. It is taken
//  on req_valid & req_ready; req_ready is high only while the block is idle.
//  One response follows each request on rsp_valid / rsp_ready with flux angle,
//  sync speed, magnetizing current and slip speed.
//  All products, quotients and angle wraps run through one bit-serial
//  shift-add / restoring-divide unit, one bit per cycle: two divides of
//  32+FRAC_BITS steps and seven 32-step passes, each pass followed by the
//  finish and post states, with the clamp and wrap-load states as glue.
//  Once the response is loaded into the output registers the block returns
//  to idle, where the next request is taken.
//  A new request may be taken while a response waits; if the previous
//  response is still stalled when the next one finishes, the block holds.
//  Reset clears the state to its start values and loads the default period
//  and time constant. CSR writes take effect at once and belong to idle time.
// ---------------------------------------------------------------------------
module rotor_flux_angle_estimator_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [31:0]     req_torque_current,
   input  logic signed [31:0]     req_flux_current,
   input  logic signed [31:0]     req_rotor_speed,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [30:0]            rsp_flux_angle,
   output logic signed [31:0]     rsp_sync_speed,
   output logic signed [31:0]     rsp_magnetizing_current,
   output logic signed [31:0]     rsp_slip_speed,
   input  logic                   csr_write,
   input  rfae_pkg::csr_index_type csr_index,
   input  logic [30:0]            csr_data
);
   import rfae_pkg::*;

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [31:0]          a_ff, a_in;
   logic [31:0]          hi_ff, hi_in;
   logic [31:0]          ml_ff, ml_in;
   logic [NUM_W-1:0]     dq_ff, dq_in;
   logic                 neg_ff, neg_in;
   logic                 zero_ff, zero_in;
   logic [31:0]          res_ff, res_in;
   logic [31:0]          tmp_ff, tmp_in;
   logic [31:0]          iq_ff, iq_in;
   logic [31:0]          wr_ff, wr_in;
   logic [31:0]          diff_ff, diff_in;
   logic [31:0]          mag_ff, mag_in;
   logic [31:0]          slip_angle_ff, slip_angle_in;
   logic [31:0]          rotor_angle_ff, rotor_angle_in;
   logic [31:0]          slip_ff, slip_in;
   logic [31:0]          sync_ff, sync_in;
   logic [30:0]          ts_ff, tr_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [30:0]          out_flux_ff, out_flux_in;
   logic [31:0]          out_sync_ff, out_sync_in;
   logic [31:0]          out_mag_ff, out_mag_in;
   logic [31:0]          out_slip_ff, out_slip_in;

   logic                 ld_en;
   op_type               ld_op;
   kind_type             ld_kind, run_kind;
   logic [31:0]          ld_x, ld_y, ld_xm, ld_ym;
   logic [32:0]          mul_sum;
   logic [32:0]          div_rem;
   logic                 div_ge;
   logic [63:0]          prod;
   logic [NUM_W-1:0]     prod_s, quot_s;
   logic [31:0]          mag_clamped;

   assign req_ready               = (state_ff == ST_IDLE);
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_flux_angle          = out_flux_ff;
   assign rsp_sync_speed          = out_sync_ff;
   assign rsp_magnetizing_current = out_mag_ff;
   assign rsp_slip_speed          = out_slip_ff;

   assign run_kind    = op_kind(op_ff);
   assign mul_sum     = {1'b0, hi_ff} + (ml_ff[0] ? {1'b0, a_ff} : 33'd0);
   assign div_rem     = {hi_ff, dq_ff[NUM_W-1]};
   assign div_ge      = (div_rem >= {1'b0, a_ff});
   assign prod        = {hi_ff, ml_ff};
   assign prod_s      = neg_ff ? (~prod[NUM_W-1:0] + 1'b1) : prod[NUM_W-1:0];
   assign quot_s      = neg_ff ? (~dq_ff + 1'b1) : dq_ff;
   assign mag_clamped = ($signed(mag_ff) <= $signed(CLAMP_LIM)) ? MIN_IMR : mag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         op_ff          <= OP_GAIN;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         mag_ff         <= 32'd1;
         slip_angle_ff  <= '0;
         rotor_angle_ff <= '0;
         ts_ff          <= RESET_SAMPLE_PERIOD;
         tr_ff          <= RESET_ROTOR_TC;
      end else begin
         state_ff       <= state_in;
         op_ff          <= op_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         mag_ff         <= mag_in;
         slip_angle_ff  <= slip_angle_in;
         rotor_angle_ff <= rotor_angle_in;
         if (csr_write) begin
            case (csr_index)
               CSR_SAMPLE_PERIOD: ts_ff <= csr_data;
               CSR_ROTOR_TC:      tr_ff <= csr_data;
               default:           ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      hi_ff       <= hi_in;
      ml_ff       <= ml_in;
      dq_ff       <= dq_in;
      neg_ff      <= neg_in;
      zero_ff     <= zero_in;
      res_ff      <= res_in;
      tmp_ff      <= tmp_in;
      iq_ff       <= iq_in;
      wr_ff       <= wr_in;
      diff_ff     <= diff_in;
      slip_ff     <= slip_in;
      sync_ff     <= sync_in;
      out_flux_ff <= out_flux_in;
      out_sync_ff <= out_sync_in;
      out_mag_ff  <= out_mag_in;
      out_slip_ff <= out_slip_in;
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      cnt_in         = cnt_ff;
      a_in           = a_ff;
      hi_in          = hi_ff;
      ml_in          = ml_ff;
      dq_in          = dq_ff;
      neg_in         = neg_ff;
      zero_in        = zero_ff;
      res_in         = res_ff;
      tmp_in         = tmp_ff;
      iq_in          = iq_ff;
      wr_in          = wr_ff;
      diff_in        = diff_ff;
      mag_in         = mag_ff;
      slip_angle_in  = slip_angle_ff;
      rotor_angle_in = rotor_angle_ff;
      slip_in        = slip_ff;
      sync_in        = sync_ff;
      out_flux_in    = out_flux_ff;
      out_sync_in    = out_sync_ff;
      out_mag_in     = out_mag_ff;
      out_slip_in    = out_slip_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      ld_en          = 1'b0;
      ld_op          = op_ff;
      ld_x           = '0;
      ld_y           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               iq_in   = req_torque_current;
               wr_in   = req_rotor_speed;
               diff_in = req_flux_current - mag_ff;
               ld_en   = 1'b1;
               ld_op   = OP_GAIN;
               ld_x    = {1'b0, ts_ff};
               ld_y    = {1'b0, tr_ff};
            end
         end
         ST_RUN: begin
            case (run_kind)
               KIND_MUL: begin
                  hi_in = mul_sum[32:1];
                  ml_in = {mul_sum[0], ml_ff[31:1]};
               end
               default: begin
                  hi_in = div_ge ? 32'(div_rem - {1'b0, a_ff}) : div_rem[31:0];
                  dq_in = {dq_ff[NUM_W-2:0], div_ge};
               end
            endcase
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            case (run_kind)
               KIND_MUL: res_in = prod_s[NUM_W-1:FRAC_BITS];
               KIND_DIV: res_in = zero_ff ? (neg_ff ? SAT_NEG : SAT_POS) : quot_s[31:0];
               default:  res_in = (neg_ff && hi_ff != '0) ? TWO_PI - hi_ff : hi_ff;
            endcase
            state_in = ST_POST;
         end
         ST_POST: begin
            case (op_ff)
               OP_GAIN: begin
                  ld_en = 1'b1;
                  ld_op = OP_MIX;
                  ld_x  = res_ff;
                  ld_y  = diff_ff;
               end
               OP_MIX: begin
                  mag_in   = mag_ff + res_ff;
                  state_in = ST_CLAMP;
               end
               OP_DEN: begin
                  ld_en = 1'b1;
                  ld_op = OP_SLIP;
                  ld_x  = iq_ff;
                  ld_y  = res_ff;
               end
               OP_SLIP: begin
                  slip_in = res_ff;
                  sync_in = wr_ff + res_ff;
                  ld_en   = 1'b1;
                  ld_op   = OP_SAM;
                  ld_x    = res_ff;
                  ld_y    = {1'b0, ts_ff};
               end
               OP_SAM: begin
                  tmp_in   = slip_angle_ff + res_ff;
                  op_in    = OP_SAW;
                  state_in = ST_WLOAD;
               end
               OP_SAW: begin
                  slip_angle_in = res_ff;
                  ld_en         = 1'b1;
                  ld_op         = OP_RAM;
                  ld_x          = wr_ff;
                  ld_y          = {1'b0, ts_ff};
               end
               OP_RAM: begin
                  tmp_in   = rotor_angle_ff + res_ff;
                  op_in    = OP_RAW;
                  state_in = ST_WLOAD;
               end
               OP_RAW: begin
                  rotor_angle_in = res_ff;
                  tmp_in         = res_ff + slip_angle_ff;
                  op_in          = OP_FAW;
                  state_in       = ST_WLOAD;
               end
               OP_FAW: begin
                  if (!rsp_valid_ff || rsp_ready) begin
                     out_flux_in  = res_ff[30:0];
                     out_sync_in  = sync_ff;
                     out_mag_in   = mag_ff;
                     out_slip_in  = slip_ff;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_CLAMP: begin
            mag_in = mag_clamped;
            ld_en  = 1'b1;
            ld_op  = OP_DEN;
            ld_x   = mag_clamped;
            ld_y   = {1'b0, tr_ff};
         end
         ST_WLOAD: begin
            ld_en = 1'b1;
            ld_op = op_ff;
            ld_x  = tmp_ff;
            ld_y  = TWO_PI;
         end
         default: state_in = ST_IDLE;
      endcase

      ld_kind = op_kind(ld_op);
      ld_xm   = ld_x[31] ? (~ld_x + 1'b1) : ld_x;
      ld_ym   = ld_y[31] ? (~ld_y + 1'b1) : ld_y;
      if (ld_en) begin
         op_in    = ld_op;
         a_in     = ld_ym;
         hi_in    = '0;
         ml_in    = ld_xm;
         dq_in    = {ld_xm, {FRAC_BITS{1'b0}}};
         neg_in   = ld_x[31] ^ ld_y[31];
         zero_in  = (ld_y == '0);
         cnt_in   = (ld_kind == KIND_DIV) ? CNT_W'(NUM_W) : CNT_W'(32);
         state_in = ST_RUN;
      end
   end

`ifndef NO_ASSERTIONS
   a_run_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> cnt_ff != '0)
      else $error("serial unit running with zero count");

   a_angles_wrapped: assert property (@(posedge clock) disable iff (reset)
      slip_angle_ff < TWO_PI && rotor_angle_ff < TWO_PI)
      else $error("stored angle outside one turn");

   a_den_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && op_ff == OP_DEN) |-> $signed(mag_ff) >= $signed(MIN_IMR))
      else $error("magnetizing current below clamp during denominator pass");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_POST && $past(op_ff) == OP_FAW)
      else $error("response raised outside final step");

   a_wrap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POST && op_kind(op_ff) == KIND_MOD) |-> res_ff < TWO_PI)
      else $error("wrapped angle outside one turn");
`endif

endmodule

/* test/rotor_flux_angle_estimator_top_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Rotor flux angle estimator testbench
// Drives torque current, flux current and rotor speed requests under several
// period and time constant settings, predicts magnetizing current, slip, sync
// speed and flux angle, and checks every response in order.
// ---------------------------------------------------------------------------
module rotor_flux_angle_estimator_top_test;
   import rfae_pkg::*;

   typedef struct {
      logic [30:0]        flux_angle;
      logic signed [31:0] sync_speed;
      logic signed [31:0] magnetizing_current;
      logic signed [31:0] slip_speed;
   } estimate_type;

   class flux_scoreboard;
      estimate_type       pending[$];
      int                 failures;
      logic signed [31:0] period, time_const, imr, slip_ang, rotor_ang;

      function new();
         failures   = 0;
         period     = 655;
         time_const = 65536;
         imr        = 1;
         slip_ang   = 0;
         rotor_ang  = 0;
      endfunction

      function logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
         longint p;
         p = longint'(a) * longint'(b);
         return 32'(p >>> FRAC_BITS);
      endfunction

      function logic signed [31:0] qdiv(logic signed [31:0] a, logic signed [31:0] b);
         longint num;
         num = longint'(a) <<< FRAC_BITS;
         if (b == 0) return (num >= 0) ? SAT_POS : SAT_NEG;
         return 32'(num / longint'(b));
      endfunction

      function logic signed [31:0] wrap_2pi(logic signed [31:0] v);
         longint r;
         r = longint'(v) % longint'(TWO_PI);
         if (r < 0) r += longint'(TWO_PI);
         return 32'(r);
      endfunction

      function void set_reg(csr_index_type idx, logic [30:0] val);
         if (idx == CSR_SAMPLE_PERIOD) period = {1'b0, val};
         else time_const = {1'b0, val};
      endfunction

      function void note_request(logic signed [31:0] iq, logic signed [31:0] id,
                                 logic signed [31:0] wr);
         estimate_type       e;
         logic signed [31:0] gain, slip;
         gain = qdiv(period, time_const);
         imr  = imr + qmul(gain, id - imr);
         if (longint'(imr) * 1000 < (longint'(1) << FRAC_BITS)) imr = MIN_IMR;
         slip      = qdiv(iq, qmul(time_const, imr));
         slip_ang  = wrap_2pi(slip_ang + qmul(slip, period));
         rotor_ang = wrap_2pi(rotor_ang + qmul(wr, period));
         e.flux_angle          = 31'(wrap_2pi(rotor_ang + slip_ang));
         e.sync_speed          = wr + slip;
         e.magnetizing_current = imr;
         e.slip_speed          = slip;
         pending.push_back(e);
      endfunction

      function void check_response(estimate_type got);
         estimate_type e;
         if (pending.size() == 0) begin
            $error("unexpected response");
            failures++;
            return;
         end
         e = pending.pop_front();
         if (got.flux_angle !== e.flux_angle) begin
            $error("flux_angle expected %0d got %0d", e.flux_angle, got.flux_angle);
            failures++;
         end
         if (got.sync_speed !== e.sync_speed) begin
            $error("sync_speed expected %0d got %0d", e.sync_speed, got.sync_speed);
            failures++;
         end
         if (got.magnetizing_current !== e.magnetizing_current) begin
            $error("magnetizing_current expected %0d got %0d",
                   e.magnetizing_current, got.magnetizing_current);
            failures++;
         end
         if (got.slip_speed !== e.slip_speed) begin
            $error("slip_speed expected %0d got %0d", e.slip_speed, got.slip_speed);
            failures++;
         end
      endfunction
   endclass

   logic               clock = 0, reset = 1;
   logic               req_valid = 0, rsp_ready = 0, csr_write = 0;
   logic               req_ready, rsp_valid;
   logic signed [31:0] req_torque_current = 0, req_flux_current = 0, req_rotor_speed = 0;
   logic [30:0]        rsp_flux_angle;
   logic signed [31:0] rsp_sync_speed, rsp_magnetizing_current, rsp_slip_speed;
   csr_index_type      csr_index = CSR_SAMPLE_PERIOD;
   logic [30:0]        csr_data = 0;
   bit                 calm = 0;

   flux_scoreboard board = new();

   rotor_flux_angle_estimator_top DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      estimate_type got;
      if (reset) rsp_ready <= 0;
      else rsp_ready <= calm || ($urandom_range(99) >= 34);
      if (!reset && req_valid && req_ready)
         board.note_request(req_torque_current, req_flux_current, req_rotor_speed);
      if (!reset && rsp_valid && rsp_ready) begin
         got.flux_angle          = rsp_flux_angle;
         got.sync_speed          = rsp_sync_speed;
         got.magnetizing_current = rsp_magnetizing_current;
         got.slip_speed          = rsp_slip_speed;
         board.check_response(got);
      end
   end

   task automatic send_request(logic signed [31:0] iq, logic signed [31:0] id,
                               logic signed [31:0] wr);
      int gap;
      gap = (!calm && $urandom_range(99) < 34) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1;
      req_torque_current <= iq;
      req_flux_current   <= id;
      req_rotor_speed    <= wr;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [30:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      board.set_reg(idx, val);
      csr_write <= 0;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] scaled_value();
      logic signed [31:0] v;
      v = $urandom;
      if ($urandom_range(9) == 0) return v;
      return v >>> $urandom_range(4, 31);
   endfunction

   localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

   initial begin
      logic [30:0] sp[7], tc[7];
      sp = '{31'd655, 31'd1, 31'h7FFF_FFFF, 31'd1, 31'd3277, 31'h7FFF_FFFF, 31'd0};
      tc = '{31'd65536, 31'd1, 31'd1, 31'h7FFF_FFFF, 31'd6554, 31'h7FFF_FFFF, 31'd0};
      sp[6] = 31'($urandom_range(1, 32'h7FFF_FFFF));
      tc[6] = 31'($urandom_range(1, 32'h7FFF_FFFF));
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_request(0, 0, 0);
      send_request(S_MAX, S_MAX, S_MAX);
      send_request(S_MIN, S_MIN, S_MIN);
      send_request(S_MAX, 32'sd65536, S_MIN);
      send_request(S_MIN, 32'sd65536, S_MAX);
      send_request(32'sd65536, 32'sd0, 32'sd100);
      send_request(-32'sd65536, -32'sd65536, -32'sd100);
      send_request(32'sd1, 32'sd65, 32'sd1);
      send_request(-32'sd1, 32'sd66, -32'sd1);
      send_request(32'sd1000, 32'sd1 <<< 30, 32'sd1 <<< 24);
      send_request(-32'sd1000, 32'sd1 <<< 30, -(32'sd1 <<< 24));
      send_request(32'sd12345, 32'sd65536, 32'sd411774);
      send_request(32'sd12345, 32'sd65536, -32'sd411774);
      send_request(-1, -1, -1);
      drain();
      for (int ph = 0; ph < 7; ph++) begin
         write_reg(CSR_SAMPLE_PERIOD, sp[ph]);
         write_reg(CSR_ROTOR_TC, tc[ph]);
         calm = (ph == 4);
         for (int n = 0; n < 148; n++)
            send_request(scaled_value(), scaled_value(), scaled_value());
         drain();
      end
      if (board.failures == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #50ms;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
